>>> design/ptdt_pkg.sv
// ----------------------------------------------------------------------------
// ptdt_pkg: shared types and constants for the periodic task due table
// Request codes, request/result payloads and the token that walks the cells.
// ----------------------------------------------------------------------------
package ptdt_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    REQ_REGISTER = 2'd0,
    REQ_ENABLE   = 2'd1,
    REQ_TICK     = 2'd2,
    REQ_CLEAR    = 2'd3
  } req_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_ms;
    logic [31:0] interval_ms;
    logic [7:0]  target_id;
    logic        enable_value;
  } in_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] result_id;
    logic [3:0] due_count;
    logic       last;
  } out_t;

  // request token handed from cell to cell, one cell per cycle
  typedef struct packed {
    logic        valid;
    req_t        req;
    logic [31:0] now_ms;
    logic [31:0] interval_ms;
    logic [7:0]  target_id;
    logic        enable_value;
    logic [7:0]  new_id;
    logic        hit;
  } tok_t;

  // due report from one cell during a tick scan
  typedef struct packed {
    logic       valid;
    logic [7:0] id;
  } rpt_t;

endpackage

>>> design/ptdt_cell.sv
// ----------------------------------------------------------------------------
// ptdt_cell: one task slot of the chain
// Acts on the request token passing by, then hands the token to the next cell.
// ----------------------------------------------------------------------------
module ptdt_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  ptdt_pkg::tok_t  tok_i,
  output ptdt_pkg::tok_t  tok_o,
  output ptdt_pkg::rpt_t  rpt_o
);

  logic           used_r, used_nxt;
  logic           en_r, en_nxt;
  logic [7:0]     id_r, id_nxt;
  logic [31:0]    intv_r, intv_nxt;
  logic [31:0]    last_r, last_nxt;
  ptdt_pkg::tok_t tok_r, tok_nxt;
  ptdt_pkg::rpt_t rpt_r, rpt_nxt;
  logic [31:0]    elapsed;

  assign elapsed = tok_i.now_ms - last_r;

  always_comb begin
    used_nxt    = used_r;
    en_nxt      = en_r;
    id_nxt      = id_r;
    intv_nxt    = intv_r;
    last_nxt    = last_r;
    tok_nxt     = tok_i;
    rpt_nxt     = '0;
    rpt_nxt.id  = id_r;
    if (tok_i.valid) begin
      case (tok_i.req)
        ptdt_pkg::REQ_REGISTER: begin
          if (!tok_i.hit && (tok_i.interval_ms != '0) && !used_r) begin
            used_nxt    = 1'b1;
            en_nxt      = 1'b1;
            id_nxt      = tok_i.new_id;
            intv_nxt    = tok_i.interval_ms;
            last_nxt    = tok_i.now_ms;
            tok_nxt.hit = 1'b1;
          end
        end
        ptdt_pkg::REQ_ENABLE: begin
          if (!tok_i.hit && (tok_i.target_id != '0) && used_r &&
              (id_r == tok_i.target_id)) begin
            en_nxt = tok_i.enable_value;
            if (tok_i.enable_value) begin
              last_nxt = tok_i.now_ms;
            end
            tok_nxt.hit = 1'b1;
          end
        end
        ptdt_pkg::REQ_TICK: begin
          if (used_r && en_r && (elapsed >= intv_r)) begin
            last_nxt      = tok_i.now_ms;
            rpt_nxt.valid = 1'b1;
          end
        end
        ptdt_pkg::REQ_CLEAR: begin
          used_nxt = 1'b0;
          en_nxt   = 1'b0;
          id_nxt   = '0;
          intv_nxt = '0;
          last_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      en_r   <= 1'b0;
      id_r   <= '0;
      intv_r <= '0;
      last_r <= '0;
      tok_r  <= '0;
      rpt_r  <= '0;
    end else begin
      used_r <= used_nxt;
      en_r   <= en_nxt;
      id_r   <= id_nxt;
      intv_r <= intv_nxt;
      last_r <= last_nxt;
      tok_r  <= tok_nxt;
      rpt_r  <= rpt_nxt;
    end
  end

  assign tok_o = tok_r;
  assign rpt_o = rpt_r;

endmodule

>>> design/ptdt_collect.sv
// ----------------------------------------------------------------------------
// ptdt_collect: result builder at the end of the chain
// Holds back one due id so the final one can carry last and the due count.
// ----------------------------------------------------------------------------
module ptdt_collect (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            clr,
  input  ptdt_pkg::rpt_t  rpt_i,
  input  ptdt_pkg::tok_t  end_tok_i,
  output logic            done_o,
  output logic            out_strobe,
  output ptdt_pkg::out_t  out_data
);

  localparam int CW = ptdt_pkg::CNT_W;

  ptdt_pkg::tok_t fin_r;
  logic           pend_v_r, pend_v_nxt;
  logic [7:0]     pend_id_r, pend_id_nxt;
  logic [CW-1:0]  n_r, n_nxt;
  logic [3:0]     cnt_r, cnt_nxt;
  logic           strobe_r, strobe_nxt;
  ptdt_pkg::out_t data_r, data_nxt;

  always_comb begin
    pend_v_nxt  = pend_v_r;
    pend_id_nxt = pend_id_r;
    n_nxt       = n_r;
    cnt_nxt     = cnt_r;
    strobe_nxt  = 1'b0;
    data_nxt    = '0;
    if (clr) begin
      pend_v_nxt = 1'b0;
      n_nxt      = '0;
      cnt_nxt    = '0;
    end else if (rpt_i.valid) begin
      if (cnt_r != 4'hF) begin
        cnt_nxt = cnt_r + 4'd1;
      end
      if (n_r < CW'(ptdt_pkg::MAX_RESULTS)) begin
        n_nxt       = n_r + CW'(1);
        pend_v_nxt  = 1'b1;
        pend_id_nxt = rpt_i.id;
        // the held id is known not to be the last one now
        if (pend_v_r) begin
          strobe_nxt         = 1'b1;
          data_nxt.ok        = 1'b1;
          data_nxt.result_id = pend_id_r;
        end
      end
    end
    if (fin_r.valid) begin
      strobe_nxt    = 1'b1;
      data_nxt.last = 1'b1;
      case (fin_r.req)
        ptdt_pkg::REQ_REGISTER: begin
          data_nxt.ok        = fin_r.hit;
          data_nxt.result_id = fin_r.hit ? fin_r.new_id : 8'd0;
        end
        ptdt_pkg::REQ_ENABLE: begin
          data_nxt.ok = fin_r.hit;
        end
        ptdt_pkg::REQ_TICK: begin
          if (pend_v_r) begin
            data_nxt.ok        = 1'b1;
            data_nxt.result_id = pend_id_r;
            data_nxt.due_count = cnt_r;
          end
        end
        ptdt_pkg::REQ_CLEAR: begin
          data_nxt.ok = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_r     <= '0;
      pend_v_r  <= 1'b0;
      pend_id_r <= '0;
      n_r       <= '0;
      cnt_r     <= '0;
      strobe_r  <= 1'b0;
      data_r    <= '0;
    end else begin
      fin_r     <= end_tok_i;
      pend_v_r  <= pend_v_nxt;
      pend_id_r <= pend_id_nxt;
      n_r       <= n_nxt;
      cnt_r     <= cnt_nxt;
      strobe_r  <= strobe_nxt;
      data_r    <= data_nxt;
    end
  end

  assign done_o     = fin_r.valid;
  assign out_strobe = strobe_r;
  assign out_data   = data_r;

endmodule

>>> design/periodic_task_due_table_top.sv
// The last result of a request passes the token register, every slot cell, then the
// collector's end and output registers; one request in flight, none taken while busy.
// Every request walks the whole chain of slot cells, one cell per cycle.
// Tick scans give up to MAX_RESULTS strobed results, at most one per cycle.
// Synchronous active-low reset empties all slots and sets the next id to one.
// The receiver cannot stall results; each is strobed for one cycle.
// ----------------------------------------------------------------------------
// periodic_task_due_table_top: periodic task due table
// A chain of slot cells with an id counter and a result builder at the end.
// ----------------------------------------------------------------------------
module periodic_task_due_table_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  ptdt_pkg::in_t   in_data,
  output logic            busy,
  output logic            out_strobe,
  output ptdt_pkg::out_t  out_data
);

  localparam int N = ptdt_pkg::NUM_SLOTS;

  logic           accept;
  logic           busy_r, busy_nxt;
  logic [7:0]     next_id_r, next_id_nxt;
  ptdt_pkg::tok_t tok0_r, tok0_nxt;
  ptdt_pkg::tok_t tok [N+1];
  ptdt_pkg::rpt_t rpt [N];
  ptdt_pkg::rpt_t rpt_any;
  logic           done;

  assign accept = start && !busy_r;

  always_comb begin
    tok0_nxt              = '0;
    tok0_nxt.valid        = accept;
    tok0_nxt.req          = ptdt_pkg::req_t'(in_data.req_type);
    tok0_nxt.now_ms       = in_data.now_ms;
    tok0_nxt.interval_ms  = in_data.interval_ms;
    tok0_nxt.target_id    = in_data.target_id;
    tok0_nxt.enable_value = in_data.enable_value;
    tok0_nxt.new_id       = next_id_r;
  end

  assign tok[0] = tok0_r;

  for (genvar i = 0; i < N; i++) begin : g_cell
    ptdt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (tok[i]),
      .tok_o (tok[i+1]),
      .rpt_o (rpt[i])
    );
  end

  // only the cell holding the token can report, so an OR is enough
  always_comb begin
    rpt_any = '0;
    for (int i = 0; i < N; i++) begin
      rpt_any.valid = rpt_any.valid | rpt[i].valid;
      rpt_any.id    = rpt_any.id | (rpt[i].id & {8{rpt[i].valid}});
    end
  end

  ptdt_collect u_collect (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr        (accept),
    .rpt_i      (rpt_any),
    .end_tok_i  (tok[N]),
    .done_o     (done),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  always_comb begin
    next_id_nxt = next_id_r;
    if (tok[N].valid) begin
      if ((tok[N].req == ptdt_pkg::REQ_REGISTER) && tok[N].hit) begin
        next_id_nxt = (next_id_r == 8'hFF) ? 8'd1 : next_id_r + 8'd1;
      end else if (tok[N].req == ptdt_pkg::REQ_CLEAR) begin
        next_id_nxt = 8'd1;
      end
    end
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      next_id_r <= 8'd1;
      tok0_r    <= '0;
    end else begin
      busy_r    <= busy_nxt;
      next_id_r <= next_id_nxt;
      tok0_r    <= tok0_nxt;
    end
  end

  assign busy = busy_r;

endmodule

>>> design/ptdt_checker.sv
// ----------------------------------------------------------------------------
// ptdt_checker: port-level checks for the periodic task due table
// Watches request acceptance and the shape of the strobed results.
// ----------------------------------------------------------------------------
module ptdt_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_strobe,
  input ptdt_pkg::out_t out_data
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted request");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.last |-> !busy)
    else $error("still busy on the final result");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.last |-> busy && out_data.ok && (out_data.due_count == 4'd0))
    else $error("bad intermediate tick result");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.ok |-> (out_data.result_id == 8'd0) &&
                                   (out_data.due_count == 4'd0))
    else $error("failed result carries an id or count");

endmodule

bind periodic_task_due_table_top ptdt_checker u_ptdt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);
